/* hdl/ffla_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared types and constants for the first-fit interval lane assigner.
// ----------------------------------------------------------------------------
package ffla_pkg;

    localparam int TIME_W      = 48;
    localparam int BORDER_W    = 16;
    localparam int LANE_W      = 4;
    localparam int SLOT_W      = 6;
    localparam int GUARD_SHIFT = 2;   // guard margin is four borders

    localparam logic [BORDER_W-1:0] BORDER_RESET = 16'd5;

    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture an accepted item and restart the scan
        logic clear;     // empty every lane
        logic skip;      // move to the next lane
        logic issue;     // read the next stored interval of the current lane
        logic place;     // store the interval in the current lane
        logic out_load;  // move the result into the output register
    } ffla_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;       // current lane has no free slot
        logic hit;        // interval compared this cycle lies within the guard
        logic exhausted;  // every stored interval of the lane has been read
        logic last_lane;  // current lane is the highest one
        logic out_busy;   // output register holds a result not yet taken
    } ffla_sts_t;

endpackage
`default_nettype wire

/* hdl/ffla_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffla_if
// Valid/ready channels for items and results of the lane assigner.
// ----------------------------------------------------------------------------
interface ffla_item_if;
    import ffla_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;

    modport source (output valid, kind, start_time, end_time, input ready);
    modport sink   (input valid, kind, start_time, end_time, output ready);
endinterface

interface ffla_result_if;
    import ffla_pkg::*;

    logic              valid;
    logic              ready;
    logic              placed;
    logic [LANE_W-1:0] lane;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, placed, lane, slot, input ready);
    modport sink   (input valid, placed, lane, slot, output ready);
endinterface
`default_nettype wire

/* hdl/first_fit_interval_lane_assign_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_interval_lane_assign_top
// First-fit lane assignment of time intervals with a guard margin.
// ----------------------------------------------------------------------------
// A clear item empties every lane, then loads the output register. A
//   placement skips each full lane and otherwise reads and compares the
//   lane's stored intervals in order; a conflict moves it to the next lane,
//   and the first lane with no conflict takes the interval. The result (not
//   placed if no lane fits) then goes to the output register. Throughput:
//   one item at a time; the store's single read port gives one compare a
//   cycle. Reset clears lane counts and the border to 5; the store needs none.
// ----------------------------------------------------------------------------
module first_fit_interval_lane_assign_top #(
    parameter int LANES = 16,
    parameter int SLOTS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ffla_pkg::BORDER_W-1:0] cfg_wr_data,
    ffla_item_if.sink                          item,
    ffla_result_if.source                      result
);
    import ffla_pkg::*;

    ffla_cmd_t cmd;
    ffla_sts_t sts;
    logic      ready;

    // The controller accepts an item only while no other item is in hand; the
    // output register lets the next item be taken while a result waits.
    ffla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .item_ready (ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    assign item.ready = ready;

    // The datapath holds the border register, the lane counts, the interval
    // store and the comparator, and registers the result for transfer.
    ffla_dp #(
        .LANES (LANES),
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_start  (item.start_time),
        .item_end    (item.end_time),
        .res_valid   (result.valid),
        .res_ready   (result.ready),
        .res_placed  (result.placed),
        .res_lane    (result.lane),
        .res_slot    (result.slot)
    );

    a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load == (item.valid && ready))
        else $error("item captured without a transfer");

endmodule
`default_nettype wire

/* hdl/ffla_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffla_ctrl
// Sequencer that walks lanes and stored intervals for one item at a time.
// ----------------------------------------------------------------------------
module ffla_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire logic                item_kind,
    output logic                     item_ready,
    input  wire ffla_pkg::ffla_sts_t sts,
    output ffla_pkg::ffla_cmd_t      cmd
);
    import ffla_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (item_kind == KIND_CLEAR)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.full || sts.hit)
                begin
                    if (sts.last_lane)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.skip = 1'b1;
                    end
                end
                else if (sts.exhausted)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> (!sts.full && !sts.hit && sts.exhausted))
        else $error("placement into a full or conflicting lane");

    a_scan_after_place_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !cmd.clear) |=> (state_reg == S_SCAN))
        else $error("placement item did not start a scan");

    a_single_action: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.place && (cmd.skip || cmd.issue)) && !(cmd.skip && cmd.issue))
        else $error("conflicting scan commands");

endmodule
`default_nettype wire

/* hdl/ffla_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffla_dp
// Lane counts, interval store, guard window, comparator and result register.
// ----------------------------------------------------------------------------
module ffla_dp #(
    parameter int LANES = 16,
    parameter int SLOTS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ffla_pkg::ffla_cmd_t           cmd,
    output ffla_pkg::ffla_sts_t                sts,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ffla_pkg::BORDER_W-1:0] cfg_wr_data,
    input  wire logic [ffla_pkg::TIME_W-1:0]   item_start,
    input  wire logic [ffla_pkg::TIME_W-1:0]   item_end,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic                               res_placed,
    output logic [ffla_pkg::LANE_W-1:0]        res_lane,
    output logic [ffla_pkg::SLOT_W-1:0]        res_slot
);
    import ffla_pkg::*;

    localparam int LW      = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW      = $clog2(SLOTS + 1);
    localparam int DEPTH   = LANES * (2 ** SW);
    localparam int MARGIN_W = BORDER_W + GUARD_SHIFT;

    localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(SLOTS);

    // Configuration.
    logic [BORDER_W-1:0] border_reg;

    // Item and scan state.
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] end_reg;
    logic [TIME_W-1:0] lo_reg;
    logic [TIME_W:0]   hi_reg;
    logic [LW-1:0]     lane_reg;
    logic [CW-1:0]     slot_idx_reg;
    logic              cmp_valid_reg;
    logic [CW-1:0]     lane_count_reg [LANES];

    // Interval store, start in the upper half and end in the lower half.
    logic [2*TIME_W-1:0] mem [DEPTH];
    logic [2*TIME_W-1:0] rdata_reg;

    // Result holding and output registers.
    logic              pend_placed_reg;
    logic [LANE_W-1:0] pend_lane_reg;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic              out_valid_reg;
    logic              out_placed_reg;
    logic [LANE_W-1:0] out_lane_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    logic [BORDER_W-1:0]   border_eff;
    logic [MARGIN_W-1:0]   margin;
    logic [TIME_W-1:0]     margin_x;
    logic [TIME_W-1:0]     lo_calc;
    logic [TIME_W:0]       hi_calc;
    logic [CW-1:0]         count_cur;
    logic [LW+SW-1:0]      rd_addr;
    logic [LW+SW-1:0]      wr_addr;
    logic [LW+LANE_W-1:0]  lane_ext;
    logic [SW+SLOT_W-1:0]  slot_ext;
    logic [TIME_W-1:0]     rd_start;
    logic [TIME_W-1:0]     rd_end;

    // Guard window worked out once per item.
    assign border_eff = (border_reg == '0) ? BORDER_W'(1) : border_reg;
    assign margin     = {border_eff, {GUARD_SHIFT{1'b0}}};
    assign margin_x   = TIME_W'(margin);
    assign lo_calc    = (item_start > margin_x) ? (item_start - margin_x) : '0;
    assign hi_calc    = {1'b0, item_end} + {1'b0, margin_x};

    assign count_cur = lane_count_reg[lane_reg];
    assign rd_addr   = {lane_reg, slot_idx_reg[SW-1:0]};
    assign wr_addr   = {lane_reg, count_cur[SW-1:0]};
    assign lane_ext  = {{LANE_W{1'b0}}, lane_reg};
    assign slot_ext  = {{SLOT_W{1'b0}}, count_cur[SW-1:0]};
    assign rd_start  = rdata_reg[2*TIME_W-1:TIME_W];
    assign rd_end    = rdata_reg[TIME_W-1:0];

    always_comb
    begin
        sts.full      = (count_cur == FULL_CNT);
        sts.hit       = cmp_valid_reg && ({1'b0, rd_start} <= hi_reg) && (rd_end >= lo_reg);
        sts.exhausted = (slot_idx_reg == count_cur);
        sts.last_lane = (lane_reg == LAST_LANE);
        sts.out_busy  = out_valid_reg && !res_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg    <= BORDER_RESET;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                lane_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                border_reg <= cfg_wr_data;
            end
            cmp_valid_reg <= cmd.issue;
            if (cmd.clear)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    lane_count_reg[i] <= '0;
                end
            end
            else if (cmd.place)
            begin
                lane_count_reg[lane_reg] <= count_cur + CW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg       <= item_start;
            end_reg         <= item_end;
            lo_reg          <= lo_calc;
            hi_reg          <= hi_calc;
            lane_reg        <= '0;
            slot_idx_reg    <= '0;
            pend_placed_reg <= 1'b0;
            pend_lane_reg   <= '0;
            pend_slot_reg   <= '0;
        end
        else if (cmd.skip)
        begin
            lane_reg     <= lane_reg + LW'(1);
            slot_idx_reg <= '0;
        end
        else if (cmd.issue)
        begin
            slot_idx_reg <= slot_idx_reg + CW'(1);
        end
        if (cmd.place)
        begin
            pend_placed_reg <= 1'b1;
            pend_lane_reg   <= lane_ext[LANE_W-1:0];
            pend_slot_reg   <= slot_ext[SLOT_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_placed_reg <= pend_placed_reg;
            out_lane_reg   <= pend_lane_reg;
            out_slot_reg   <= pend_slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place)
        begin
            mem[wr_addr] <= {start_reg, end_reg};
        end
        if (cmd.issue)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_placed = out_placed_reg;
    assign res_lane   = out_lane_reg;
    assign res_slot   = out_slot_reg;

    a_issue_then_compare: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> cmp_valid_reg)
        else $error("read data not marked for comparison");

    a_out_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || res_ready))
        else $error("result overwritten before transfer");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (lane_count_reg[0] == '0))
        else $error("lane count not cleared");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit interval lane assigner. A scoreboard
// class predicts the lane and slot of every transfer on the item channel.
// Each result is checked against the oldest prediction. Directed corner cases
// come first. Then come phases of random bursts under several border
// settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffla_pkg::*;

    localparam int N_LANES      = 16;
    localparam int N_SLOTS      = 64;
    localparam int RESET_CYCLES = 7;
    // The longest quiet stretch of a correct run is the long receiver hold-off
    // plus a full scan of every lane; the limit allows several times that.
    localparam int HOLD_AT      = 160;
    localparam int LONG_HOLD    = 2000;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int PHASE_ITEMS  = 92;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic              placed;
        logic [LANE_W-1:0] lane;
        logic [SLOT_W-1:0] slot;
    } placement_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds a private copy of the lane contents and the border,
    // predicts a placement for every item transfer and queues it until the
    // matching result transfer turns up.
    // ------------------------------------------------------------------------
    class lane_assign_scoreboard;
        logic [BORDER_W-1:0] border;
        logic [6:0]          lane_fill  [N_LANES];
        logic [TIME_W-1:0]   lane_start [N_LANES][N_SLOTS];
        logic [TIME_W-1:0]   lane_end   [N_LANES][N_SLOTS];
        placement_t          expected_placements [$];
        int                  errors;

        function new();
            border = BORDER_RESET;
            foreach (lane_fill[i]) lane_fill[i] = '0;
            errors = 0;
        endfunction

        function void set_border(input logic [BORDER_W-1:0] value);
            border = value;
        endfunction

        function int outstanding();
            return expected_placements.size();
        endfunction

        // First fit: lowest lane with room and nothing inside the guarded
        // window; the window's lower edge stops at zero, the upper one is
        // one bit wider than a timestamp so that it cannot wrap.
        function placement_t first_fit_place(input logic kind,
                                             input logic [TIME_W-1:0] st,
                                             input logic [TIME_W-1:0] en);
            placement_t                     res;
            logic [BORDER_W-1:0]            eff;
            logic [BORDER_W+GUARD_SHIFT-1:0] margin;
            logic [TIME_W-1:0]              lo;
            logic [TIME_W:0]                hi;
            bit                             clash;
            int                             n;
            res = '0;
            if (kind == KIND_CLEAR)
            begin
                foreach (lane_fill[i]) lane_fill[i] = '0;
                return res;
            end
            eff    = (border == '0) ? BORDER_W'(1) : border;
            margin = {{GUARD_SHIFT{1'b0}}, eff} << GUARD_SHIFT;
            lo     = (st > margin) ? st - margin : '0;
            hi     = {1'b0, en} + margin;
            for (int l = 0; l < N_LANES; l++)
            begin
                n = lane_fill[l];
                if (n >= N_SLOTS)
                    continue;
                clash = 1'b0;
                for (int j = 0; j < n; j++)
                begin
                    if ({1'b0, lane_start[l][j]} <= hi && lane_end[l][j] >= lo)
                        clash = 1'b1;
                end
                if (clash)
                    continue;
                lane_start[l][n] = st;
                lane_end[l][n]   = en;
                lane_fill[l]     = lane_fill[l] + 1'b1;
                res.placed = 1'b1;
                res.lane   = LANE_W'(l);
                res.slot   = SLOT_W'(n);
                return res;
            end
            return res;
        endfunction

        function void note_item(input logic kind, input logic [TIME_W-1:0] st,
                                input logic [TIME_W-1:0] en);
            expected_placements.push_back(first_fit_place(kind, st, en));
        endfunction

        function void check_result(input logic placed, input logic [LANE_W-1:0] lane,
                                   input logic [SLOT_W-1:0] slot);
            placement_t exp_res;
            if (expected_placements.size() == 0)
            begin
                $error("result transfer with no placement outstanding");
                errors++;
                return;
            end
            exp_res = expected_placements.pop_front();
            if (placed !== exp_res.placed)
            begin
                $error("placed: expected %0d, actual %0d", exp_res.placed, placed);
                errors++;
            end
            if (lane !== exp_res.lane)
            begin
                $error("lane: expected %0d, actual %0d", exp_res.lane, lane);
                errors++;
            end
            if (slot !== exp_res.slot)
            begin
                $error("slot: expected %0d, actual %0d", exp_res.slot, slot);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [BORDER_W-1:0] cfg_wr_data;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ffla_item_if   item_ch ();
    ffla_result_if result_ch ();

    first_fit_interval_lane_assign_top #(
        .LANES (N_LANES),
        .SLOTS (N_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    lane_assign_scoreboard sb = new();

    logic [BORDER_W-1:0] border_now = BORDER_RESET;
    bit                  sender_steady = 1'b0;

    // Idle lengths: mostly none, some short, a few long. A steady stretch
    // suppresses idling altogether.
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[TIME_W-1:0];
    endfunction

    // Starting points for bursts: anywhere, close to zero so that the lower
    // guard edge saturates, or close to the top of the timestamp range.
    function automatic logic [TIME_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return rand_time();
        if (r < 85)
            return TIME_W'($urandom_range(0, 200));
        return TIME_MAX - TIME_W'($urandom_range(0, 200));
    endfunction

    // ------------------------------------------------------------------------
    // Item channel driver. Valid is held high between back-to-back items, so
    // it is assigned once per time step. A transfer is seen at the edge where
    // the sampled ready is high while valid is up.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [TIME_W-1:0] st,
                             input logic [TIME_W-1:0] en);
        int gap;
        gap = pick_gap(sender_steady);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= kind;
        item_ch.start_time <= st;
        item_ch.end_time   <= en;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        sb.note_item(kind, st, en);
    endtask

    // The sender stops offering and waits for every outstanding result; this
    // is the only time the border register may change.
    task automatic wait_until_drained();
        item_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_border(input logic [BORDER_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        border_now = value;
        sb.set_border(value);
    endtask

    // Directed corners under the reset border of 5, so the guard is 20.
    task automatic run_directed();
        send_item(KIND_PLACE, '0, '0);              // lower guard edge at zero
        send_item(KIND_PLACE, TIME_MAX, TIME_MAX);  // upper edge beyond 48 bits
        send_item(KIND_PLACE, 48'd100, 48'd200);
        send_item(KIND_PLACE, 48'd221, 48'd300);    // one past the guard: same lane
        send_item(KIND_PLACE, 48'd320, 48'd400);    // touches the guard: next lane
        send_item(KIND_PLACE, 48'd50, 48'd500);     // encloses stored intervals
        send_item(KIND_PLACE, 48'd1000, 48'd900);   // end before start
        send_item(KIND_CLEAR, rand_time(), rand_time());
        // An interval spanning all time blocks lane 0 for everything after it;
        // identical intervals then take lanes 1 to 15, and the last one finds
        // no room at all.
        send_item(KIND_PLACE, '0, TIME_MAX);
        for (int k = 0; k < N_LANES; k++)
            send_item(KIND_PLACE, 48'd1000, 48'd2000);
    endtask

    // Random bursts: overlapping clusters to spread across lanes and run out
    // of room, tiled runs that fill a lane to the end, noise, clears and
    // extreme timestamps.
    task automatic run_random_phase(input int quota);
        int                done_items;
        int                pick;
        int                n;
        int                guard;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] st;
        logic [TIME_W-1:0] en;
        logic [TIME_W-1:0] t;
        done_items = 0;
        guard = 4 * ((border_now == '0) ? 1 : int'(border_now));
        while (done_items < quota)
        begin
            pick          = $urandom_range(0, 99);
            sender_steady = ($urandom_range(0, 4) == 0);
            base          = pick_base();
            if (pick < 40)
            begin
                n = $urandom_range(4, 24);
                for (int k = 0; k < n && done_items < quota; k++)
                begin
                    st = base + TIME_W'($urandom_range(0, 8 * guard));
                    if ($urandom_range(0, 11) == 0)
                        en = st - TIME_W'($urandom_range(1, guard));
                    else
                        en = st + TIME_W'($urandom_range(0, 2 * guard));
                    send_item(KIND_PLACE, st, en);
                    done_items++;
                end
            end
            else if (pick < 65)
            begin
                n = $urandom_range(16, 72);
                t = base;
                for (int k = 0; k < n && done_items < quota; k++)
                begin
                    st = t;
                    en = t + TIME_W'($urandom_range(0, 3 * guard));
                    send_item(KIND_PLACE, st, en);
                    done_items++;
                    // Now and then the next one lands inside the guard.
                    if ($urandom_range(0, 7) == 0)
                        t = en + TIME_W'($urandom_range(0, guard));
                    else
                        t = en + TIME_W'(guard + $urandom_range(1, 2 * guard));
                end
            end
            else if (pick < 85)
            begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n && done_items < quota; k++)
                begin
                    send_item(KIND_PLACE, rand_time(), rand_time());
                    done_items++;
                end
            end
            else if (pick < 95)
            begin
                send_item(KIND_CLEAR, rand_time(), rand_time());
                done_items++;
            end
            else
            begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n && done_items < quota; k++)
                begin
                    st = ($urandom_range(0, 1) == 0) ? '0 : TIME_MAX;
                    en = ($urandom_range(0, 1) == 0) ? '0 : TIME_MAX;
                    send_item(KIND_PLACE, st, en);
                    done_items++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stalls, with steady stretches, and one long
    // hold-off partway through a phase so that the block backs up and the
    // item channel stalls while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin
        int results_taken;
        int stall;
        bit recv_steady;
        results_taken   = 0;
        stall           = 0;
        recv_steady     = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                sb.check_result(result_ch.placed, result_ch.lane, result_ch.slot);
                results_taken++;
                if ($urandom_range(0, 29) == 0)
                    recv_steady = !recv_steady;
                stall = pick_gap(recv_steady);
                if (results_taken == HOLD_AT)
                    stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles with no transfer on either channel.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed corners at the reset border, then
    // random phases under a range of borders including zero (taken as one),
    // one and the maximum. Every border change waits for the block to drain.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [BORDER_W-1:0] phase_border [6];
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        item_ch.valid      = 1'b0;
        item_ch.kind       = KIND_PLACE;
        item_ch.start_time = '0;
        item_ch.end_time   = '0;

        phase_border[0] = '0;
        phase_border[1] = BORDER_W'(1);
        phase_border[2] = '1;
        phase_border[3] = BORDER_W'($urandom_range(2, 300));
        phase_border[4] = BORDER_RESET;
        phase_border[5] = BORDER_W'($urandom_range(1, 65535));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_until_drained();

        foreach (phase_border[p])
        begin
            write_border(phase_border[p]);
            run_random_phase(PHASE_ITEMS);
            wait_until_drained();
        end

        // Leave room for any stray result after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
hdl/ffla_pkg.sv
hdl/ffla_if.sv
hdl/ffla_ctrl.sv
hdl/ffla_dp.sv
hdl/first_fit_interval_lane_assign_top.sv
dv/tb_top.sv
